### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the queue unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Check that expr never holds at a rising edge outside reset.
`define SPQ_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

### design/spqdo_pkg.sv
// ----------------------------------------------------------------------------
// spqdo_pkg
// Types and codes shared by the strict priority queue modules.
// ----------------------------------------------------------------------------
package spqdo_pkg;

    localparam int NUM_FIFO_CLASSES = 3;
    localparam logic [1:0] LOW_CLASS = 2'd3;
    localparam logic [3:0] LIMIT_RESET = 4'd5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [2:0] ST_QUEUED  = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_SERVED  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_EXEC = 3'b010,
        FSM_RESP = 3'b100
    } spqdo_state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_CLASS,
        SRC_RING
    } spqdo_src_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } spqdo_cmd_t;

    typedef struct packed {
        logic out_valid;
    } spqdo_stat_t;

endpackage

### design/spqdo_ctrl.sv
// ----------------------------------------------------------------------------
// spqdo_ctrl
// Controller: sequences capture, execution and result load of one transaction.
// ----------------------------------------------------------------------------
module spqdo_ctrl
    import spqdo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        m_tready,
    input  spqdo_stat_t stat,
    output spqdo_cmd_t  cmd
);

    spqdo_state_t state_reg;
    spqdo_state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = (state_reg == FSM_IDLE);
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = FSM_RESP;
            end
            FSM_RESP:
            begin
                if (!stat.out_valid || m_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/spqdo_datapath.sv
// ----------------------------------------------------------------------------
// spqdo_datapath
// Datapath: class FIFO memory, class 3 ring, pointers and result register.
// ----------------------------------------------------------------------------
module spqdo_datapath
    import spqdo_pkg::*;
#(
    parameter int CLASS_DEPTH = 16,
    parameter int LOW_DEPTH   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  spqdo_cmd_t  cmd,
    output spqdo_stat_t stat,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [4:0]  m_tuser
);

    localparam int CAW  = $clog2(CLASS_DEPTH);
    localparam int CCW  = $clog2(CLASS_DEPTH + 1);
    localparam int MAW  = $clog2(NUM_FIFO_CLASSES * CLASS_DEPTH);
    localparam int LAW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
    localparam int LCW  = $clog2(LOW_DEPTH + 1);
    localparam int CMPW = (LCW > 4) ? LCW : 4;
    localparam logic [CCW-1:0]  CNT_FULL = CCW'(CLASS_DEPTH);
    localparam logic [CAW-1:0]  CPTR_MAX = CAW'(CLASS_DEPTH - 1);
    localparam logic [LAW-1:0]  LPTR_MAX = LAW'(LOW_DEPTH - 1);
    localparam logic [CMPW-1:0] LIM_MAX  = CMPW'(LOW_DEPTH);

    function automatic logic [CAW-1:0] cwrap(input logic [CAW-1:0] p);
        cwrap = (p == CPTR_MAX) ? '0 : p + CAW'(1);
    endfunction

    function automatic logic [LAW-1:0] lwrap(input logic [LAW-1:0] p);
        lwrap = (p == LPTR_MAX) ? '0 : p + LAW'(1);
    endfunction

    logic [CAW-1:0] head_reg [NUM_FIFO_CLASSES];
    logic [CAW-1:0] head_next[NUM_FIFO_CLASSES];
    logic [CAW-1:0] tail_reg [NUM_FIFO_CLASSES];
    logic [CAW-1:0] tail_next[NUM_FIFO_CLASSES];
    logic [CCW-1:0] cnt_reg  [NUM_FIFO_CLASSES];
    logic [CCW-1:0] cnt_next [NUM_FIFO_CLASSES];

    logic [LAW-1:0] lhead_reg, lhead_next;
    logic [LAW-1:0] ltail_reg, ltail_next;
    logic [LCW-1:0] lcnt_reg, lcnt_next;
    logic [3:0]     limit_reg;

    logic           op_reg;
    logic [1:0]     cls_reg;
    logic [31:0]    word_reg;

    logic [31:0]    cmem [NUM_FIFO_CLASSES * CLASS_DEPTH];
    logic [31:0]    cmem_rd_reg;
    logic           cmem_we, cmem_re;
    logic [MAW-1:0] cmem_waddr, cmem_raddr;

    logic [31:0]    rmem [LOW_DEPTH];
    logic [31:0]    rmem_rd_reg;
    logic           rmem_we, rmem_re;

    logic [2:0]     res_status_reg, res_status_next;
    logic [1:0]     res_class_reg, res_class_next;
    spqdo_src_t     res_src_reg, res_src_next;

    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic [1:0]     out_class_reg;
    logic [31:0]    out_word_reg;

    logic [CMPW-1:0] lim_ext;
    logic [CMPW-1:0] lcnt_ext;
    logic            evict;
    logic            found;
    logic [1:0]      pick;
    logic [CCW-1:0]  cnt_sel;

    assign lim_ext  = (limit_reg == 4'd0) ? CMPW'(1) :
                      (CMPW'(limit_reg) > LIM_MAX) ? LIM_MAX : CMPW'(limit_reg);
    assign lcnt_ext = CMPW'(lcnt_reg);
    assign evict    = (lcnt_ext >= lim_ext);

    always_comb
    begin
        found   = 1'b0;
        pick    = 2'd0;
        cnt_sel = '0;
        for (int c = NUM_FIFO_CLASSES - 1; c >= 0; c--)
        begin
            if (cnt_reg[c] != '0)
            begin
                found = 1'b1;
                pick  = 2'(c);
            end
            if (cls_reg == 2'(c))
            begin
                cnt_sel = cnt_reg[c];
            end
        end
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        lhead_next      = lhead_reg;
        ltail_next      = ltail_reg;
        lcnt_next       = lcnt_reg;
        res_status_next = res_status_reg;
        res_class_next  = res_class_reg;
        res_src_next    = res_src_reg;
        cmem_we         = 1'b0;
        cmem_re         = 1'b0;
        cmem_waddr      = '0;
        cmem_raddr      = '0;
        rmem_we         = 1'b0;
        rmem_re         = 1'b0;
        if (cmd.exec)
        begin
            res_status_next = ST_QUEUED;
            res_class_next  = 2'd0;
            res_src_next    = SRC_NONE;
            if (op_reg == CMD_ENQ)
            begin
                if (cls_reg != LOW_CLASS)
                begin
                    if (cnt_sel == CNT_FULL)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        cmem_we = 1'b1;
                        for (int c = 0; c < NUM_FIFO_CLASSES; c++)
                        begin
                            if (cls_reg == 2'(c))
                            begin
                                cmem_waddr   = MAW'(c * CLASS_DEPTH) + MAW'(tail_reg[c]);
                                tail_next[c] = cwrap(tail_reg[c]);
                                cnt_next[c]  = cnt_reg[c] + CCW'(1);
                            end
                        end
                    end
                end
                else
                begin
                    rmem_we    = 1'b1;
                    ltail_next = lwrap(ltail_reg);
                    if (evict)
                    begin
                        rmem_re         = 1'b1;
                        lhead_next      = lwrap(lhead_reg);
                        res_status_next = ST_EVICTED;
                        res_class_next  = LOW_CLASS;
                        res_src_next    = SRC_RING;
                    end
                    else
                    begin
                        lcnt_next = lcnt_reg + LCW'(1);
                    end
                end
            end
            else if (found)
            begin
                cmem_re = 1'b1;
                for (int c = 0; c < NUM_FIFO_CLASSES; c++)
                begin
                    if (pick == 2'(c))
                    begin
                        cmem_raddr   = MAW'(c * CLASS_DEPTH) + MAW'(head_reg[c]);
                        head_next[c] = cwrap(head_reg[c]);
                        cnt_next[c]  = cnt_reg[c] - CCW'(1);
                    end
                end
                res_status_next = ST_SERVED;
                res_class_next  = pick;
                res_src_next    = SRC_CLASS;
            end
            else if (lcnt_reg != '0)
            begin
                rmem_re         = 1'b1;
                lhead_next      = lwrap(lhead_reg);
                lcnt_next       = lcnt_reg - LCW'(1);
                res_status_next = ST_SERVED;
                res_class_next  = LOW_CLASS;
                res_src_next    = SRC_RING;
            end
            else
            begin
                res_status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
        begin
            cmem[cmem_waddr] <= word_reg;
        end
        if (cmem_re)
        begin
            cmem_rd_reg <= cmem[cmem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rmem_we)
        begin
            rmem[ltail_reg] <= word_reg;
        end
        if (rmem_re)
        begin
            rmem_rd_reg <= rmem[lhead_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_tuser[0];
            cls_reg  <= s_tuser[2:1];
            word_reg <= s_tdata;
        end
        res_status_reg <= res_status_next;
        res_class_reg  <= res_class_next;
        res_src_reg    <= res_src_next;
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_class_reg  <= res_class_reg;
            case (res_src_reg)
                SRC_CLASS: out_word_reg <= cmem_rd_reg;
                SRC_RING:  out_word_reg <= rmem_rd_reg;
                default:   out_word_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_FIFO_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            lhead_reg     <= '0;
            ltail_reg     <= '0;
            lcnt_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            lhead_reg <= lhead_next;
            ltail_reg <= ltail_next;
            lcnt_reg  <= lcnt_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_word_reg;
    assign m_tuser        = {out_class_reg, out_status_reg};

endmodule

### design/strict_priority_queue_with_drop_oldest_unit.sv
// ----------------------------------------------------------------------------
// strict_priority_queue_with_drop_oldest_unit
// Four-class strict priority queue with a drop-oldest class 3 ring.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction: s_tuser selects
//   enqueue or dequeue and the class, s_tdata carries id and amount.
//   Every command returns exactly one result transaction on the master
//   stream: status and class in m_tuser, id and amount in m_tdata.
//   Classes 0..2 reject when full; class 3 evicts its oldest entry once
//   the ring holds low_class_limit entries (written over cfg_data).
// Timing:
//   A command passes capture, execution with one memory access and result
//   load in turn before its result is valid; this order is set by the
//   controller sequence and the registered read of the FIFO memories. The
//   unit takes no new command until the previous result is loaded.
// Reset:
//   Clears all pointers and counts, drops any pending result and sets the
//   class 3 limit to 5. Queue memories are not cleared.
// Stall:
//   The result register holds while m_tready is low; the next command may
//   be taken meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module strict_priority_queue_with_drop_oldest_unit
    import spqdo_pkg::*;
#(
    parameter int CLASS_DEPTH = 16,
    parameter int LOW_DEPTH   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_id_in[15:0], amount_in[31:16]
    input  logic [2:0]  s_tuser,   // cmd[0], class_in[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item_id_out[15:0], amount_out[31:16]
    output logic [4:0]  m_tuser,   // status[2:0], class_out[4:3]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // low_class_limit
);

    spqdo_cmd_t  cmd;
    spqdo_stat_t stat;

    assign cfg_ready = 1'b1;

    spqdo_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spqdo_datapath #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .LOW_DEPTH   (LOW_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### design/spqdo_checker.sv
// ----------------------------------------------------------------------------
// spqdo_checker
// Port-level checks of the strict priority queue unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spqdo_checker
    import spqdo_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [4:0]  m_tuser
);

    logic [2:0] out_status;
    logic [1:0] out_class;
    logic       plain_status;

    assign out_status   = m_tuser[2:0];
    assign out_class    = m_tuser[4:3];
    assign plain_status = (out_status == ST_QUEUED) || (out_status == ST_FULL) ||
                          (out_status == ST_EMPTY);

    `SPQ_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `SPQ_ASSERT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "taken while busy")
    `SPQ_ASSERT(a_status_range, clk, rst_n, m_tvalid |-> out_status <= ST_EMPTY, "bad status code")
    `SPQ_ASSERT(a_evict_class, clk, rst_n, m_tvalid && out_status == ST_EVICTED |-> out_class == LOW_CLASS, "bad evict class")
    `SPQ_ASSERT_NEVER(a_zero_payload, clk, rst_n, m_tvalid && plain_status && (m_tdata != '0 || out_class != '0), "stray payload")

endmodule

bind strict_priority_queue_with_drop_oldest_unit spqdo_checker u_spqdo_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
